FILE: sv/spi_nor_erase_sequencer_core_defines.svh
// Assertion helpers used by the erase sequencer back end.
`ifndef SPI_NOR_ERASE_SEQUENCER_CORE_DEFINES_SVH
`define SPI_NOR_ERASE_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SNE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SNE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/sne_pkg.sv
`default_nettype none
package sne_pkg;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;

	// Live configuration registers
	typedef struct packed {
		logic [27:0] flash_bytes;
		logic [4:0]  log_erase_size;
		logic [7:0]  erase_opcode;
		logic        four_byte_addr;
		logic [15:0] block_timeout_ms;
		logic [17:0] chip_timeout_ms;
	} cfg_t;

	// Item classes handed from the front end to the sequencer
	typedef enum logic [2:0] {
		IC_REQ_CHIP,
		IC_REQ_RANGE,
		IC_REQ_EMPTY,
		IC_REQ_BAD,
		IC_STATUS,
		IC_TICK
	} item_code_t;

	typedef struct packed {
		item_code_t  code;
		logic [26:0] offset;
		logic [27:0] job_len;
		logic        busy;
	} q_item_t;

endpackage
`default_nettype wire

FILE: sv/sne_if.sv
`default_nettype none
// Request channel: erase requests, status replies and millisecond ticks
interface sne_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic        whole_chip;
	logic [26:0] offset;
	logic [27:0] length;
	logic [7:0]  status_byte;

	modport source (output valid, req_type, whole_chip, offset, length, status_byte,
		input ready);
	modport sink (input valid, req_type, whole_chip, offset, length, status_byte,
		output ready);
endinterface

// Result channel: flash commands and done reports
interface sne_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  opcode;
	logic [26:0] cmd_address;
	logic [2:0]  address_bytes;
	logic        wants_reply;
	logic [1:0]  done_status;
	logic [27:0] done_length;
	logic        last;

	modport source (output valid, kind, opcode, cmd_address, address_bytes, wants_reply,
		done_status, done_length, last, input ready);
	modport sink (input valid, kind, opcode, cmd_address, address_bytes, wants_reply,
		done_status, done_length, last, output ready);
endinterface
`default_nettype wire

FILE: sv/sne_front.sv
`default_nettype none
module sne_front
	import sne_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg,
	sne_req_if.sink                    req_ch,
	input  wire logic                  q_full,
	output logic                       push,
	output q_item_t                    push_item
);

	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BYTES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG_ERASE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE_OP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TMO   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CHIP_TMO    = 3'd5;

	localparam logic [1:0] RT_ERASE  = 2'd0;
	localparam logic [1:0] RT_STATUS = 2'd1;
	localparam logic [1:0] RT_TICK   = 2'd2;

	localparam logic [27:0] MAX_FLASH = 28'd134217728;

	cfg_t        cfg_q;
	logic [27:0] fsize;
	logic [27:0] align_mask;
	logic [27:0] off_ext;
	logic [28:0] range_end;
	logic        range_bad;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flash_bytes      <= 28'd16777216;
			cfg_q.log_erase_size   <= 5'd16;
			cfg_q.erase_opcode     <= 8'd216;
			cfg_q.four_byte_addr   <= 1'b0;
			cfg_q.block_timeout_ms <= 16'd1000;
			cfg_q.chip_timeout_ms  <= 18'd60000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FLASH_BYTES: cfg_q.flash_bytes      <= cfg_data;
				CFG_LOG_ERASE:   cfg_q.log_erase_size   <= cfg_data[4:0];
				CFG_ERASE_OP:    cfg_q.erase_opcode     <= cfg_data[7:0];
				CFG_FOUR_BYTE:   cfg_q.four_byte_addr   <= cfg_data[0];
				CFG_BLOCK_TMO:   cfg_q.block_timeout_ms <= cfg_data[15:0];
				CFG_CHIP_TMO:    cfg_q.chip_timeout_ms  <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// Clamp the flash size and check the range against it
	assign fsize      = (cfg_q.flash_bytes > MAX_FLASH) ? MAX_FLASH : cfg_q.flash_bytes;
	assign align_mask = ~({28{1'b1}} << cfg_q.log_erase_size);
	assign off_ext    = {1'b0, req_ch.offset};
	assign range_end  = {1'b0, off_ext} + {1'b0, req_ch.length};
	assign range_bad  = !(off_ext < fsize) || (range_end > {1'b0, fsize}) ||
		(|(off_ext & align_mask)) || (|(req_ch.length & align_mask));

	// Classify the incoming item
	always_comb begin
		push_item.offset  = req_ch.offset;
		push_item.job_len = req_ch.whole_chip ? fsize : req_ch.length;
		push_item.busy    = req_ch.status_byte[0];
		push_item.code    = IC_TICK;
		push              = 1'b0;
		unique case (req_ch.req_type)
			RT_ERASE: begin
				push = 1'b1;
				if (req_ch.whole_chip)
					push_item.code = IC_REQ_CHIP;
				else if (range_bad)
					push_item.code = IC_REQ_BAD;
				else if (req_ch.length == 28'd0)
					push_item.code = IC_REQ_EMPTY;
				else
					push_item.code = IC_REQ_RANGE;
			end
			RT_STATUS: begin
				push           = 1'b1;
				push_item.code = IC_STATUS;
			end
			RT_TICK: begin
				push           = 1'b1;
				push_item.code = IC_TICK;
			end
			default: push = 1'b0;
		endcase
		push = push && req_ch.valid && !q_full;
	end

	assign req_ch.ready = !q_full;

endmodule
`default_nettype wire

FILE: sv/sne_queue.sv
`default_nettype none
module sne_queue
	import sne_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire q_item_t push_item,
	input  wire logic    pop,
	output q_item_t      head,
	output logic         empty,
	output logic         full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	q_item_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));

endmodule
`default_nettype wire

FILE: sv/sne_back.sv
`default_nettype none
`include "spi_nor_erase_sequencer_core_defines.svh"
module sne_back
	import sne_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire q_item_t head,
	input  wire logic    empty,
	output logic         pop,
	sne_res_if.source    res_ch
);

	localparam logic [7:0] OP_WREN = 8'h06;
	localparam logic [7:0] OP_RDSR = 8'h05;
	localparam logic [7:0] OP_CHIP = 8'h60;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;
	localparam logic [1:0] ST_BUSY    = 2'd3;

	localparam logic PH_IDLE = 1'b0;
	localparam logic PH_POLL = 1'b1;

	localparam logic [1:0] SEQ_NONE  = 2'd0;
	localparam logic [1:0] SEQ_RDSR  = 2'd1;
	localparam logic [1:0] SEQ_ERASE = 2'd2;

	localparam logic [17:0] ELAPSED_MAX = 18'h3FFFF;

	typedef struct packed {
		logic        kind;
		logic [7:0]  opcode;
		logic [26:0] cmd_address;
		logic [2:0]  address_bytes;
		logic        wants_reply;
		logic [1:0]  done_status;
		logic [27:0] done_length;
		logic        last;
	} res_t;

	function automatic res_t mk_done(input logic [1:0] st, input logic [27:0] len);
		res_t r;
		r             = '0;
		r.kind        = 1'b1;
		r.done_status = st;
		r.done_length = len;
		r.last        = 1'b1;
		return r;
	endfunction

	function automatic res_t mk_cmd(input logic [7:0] op, input logic [26:0] addr,
		input logic [2:0] ab, input logic reply, input logic lst);
		res_t r;
		r               = '0;
		r.opcode        = op;
		r.cmd_address   = addr;
		r.address_bytes = ab;
		r.wants_reply   = reply;
		r.last          = lst;
		return r;
	endfunction

	// Job state
	logic        phase_q, phase_d;
	logic [26:0] baddr_q, baddr_d;
	logic [27:0] end_q, end_d;
	logic [17:0] elapsed_q, elapsed_d;
	logic        chip_q, chip_d;
	logic [27:0] jlen_q, jlen_d;

	// Pending tail of a three-command burst
	logic [1:0]  seq_q, seq_d;
	logic [7:0]  op2_q, op2_d;
	logic [26:0] addr2_q, addr2_d;
	logic [2:0]  ab2_q, ab2_d;
	logic        plan_we;

	// Output register
	res_t        out_q, res_d;
	logic        out_valid_q;
	logic        out_load;
	logic        res_we;

	logic [32:0] next_blk;
	logic [17:0] limit;
	logic [26:0] esrc;
	logic [26:0] eaddr;
	logic [2:0]  eab;
	logic        is_req;

	assign out_load = !out_valid_q || res_ch.ready;
	assign pop      = out_load && (seq_q == SEQ_NONE) && !empty;

	assign next_blk = {6'b0, baddr_q} + (33'd1 << cfg.log_erase_size);
	assign limit    = chip_q ? cfg.chip_timeout_ms : {2'b0, cfg.block_timeout_ms};
	assign esrc     = (head.code == IC_STATUS) ? next_blk[26:0] : head.offset;
	assign eaddr    = cfg.four_byte_addr ? esrc : {3'b0, esrc[23:0]};
	assign eab      = cfg.four_byte_addr ? 3'd4 : 3'd3;
	assign is_req   = (head.code == IC_REQ_CHIP) || (head.code == IC_REQ_RANGE) ||
		(head.code == IC_REQ_EMPTY) || (head.code == IC_REQ_BAD);

	// Execute the head item or drain the pending burst
	always_comb begin
		phase_d   = phase_q;
		baddr_d   = baddr_q;
		end_d     = end_q;
		elapsed_d = elapsed_q;
		chip_d    = chip_q;
		jlen_d    = jlen_q;
		seq_d     = seq_q;
		op2_d     = op2_q;
		addr2_d   = addr2_q;
		ab2_d     = ab2_q;
		plan_we   = 1'b0;
		res_d     = '0;
		res_we    = 1'b0;

		if (out_load && seq_q == SEQ_ERASE) begin
			res_d  = mk_cmd(op2_q, addr2_q, ab2_q, 1'b0, 1'b0);
			res_we = 1'b1;
			seq_d  = SEQ_RDSR;
		end else if (out_load && seq_q == SEQ_RDSR) begin
			res_d  = mk_cmd(OP_RDSR, 27'd0, 3'd0, 1'b1, 1'b1);
			res_we = 1'b1;
			seq_d  = SEQ_NONE;
		end else if (pop) begin
			if (is_req && phase_q == PH_POLL) begin
				// Reject a request while a job runs
				res_d  = mk_done(ST_BUSY, 28'd0);
				res_we = 1'b1;
			end else begin
				case (head.code)
					IC_REQ_CHIP: begin
						res_d     = mk_cmd(OP_WREN, 27'd0, 3'd0, 1'b0, 1'b0);
						res_we    = 1'b1;
						seq_d     = SEQ_ERASE;
						plan_we   = 1'b1;
						op2_d     = OP_CHIP;
						addr2_d   = 27'd0;
						ab2_d     = 3'd0;
						chip_d    = 1'b1;
						jlen_d    = head.job_len;
						elapsed_d = 18'd0;
						phase_d   = PH_POLL;
					end
					IC_REQ_RANGE: begin
						res_d     = mk_cmd(OP_WREN, 27'd0, 3'd0, 1'b0, 1'b0);
						res_we    = 1'b1;
						seq_d     = SEQ_ERASE;
						plan_we   = 1'b1;
						op2_d     = cfg.erase_opcode;
						addr2_d   = eaddr;
						ab2_d     = eab;
						chip_d    = 1'b0;
						jlen_d    = head.job_len;
						baddr_d   = head.offset;
						end_d     = {1'b0, head.offset} + head.job_len;
						elapsed_d = 18'd0;
						phase_d   = PH_POLL;
					end
					IC_REQ_EMPTY: begin
						res_d  = mk_done(ST_OK, 28'd0);
						res_we = 1'b1;
					end
					IC_REQ_BAD: begin
						res_d  = mk_done(ST_INVALID, 28'd0);
						res_we = 1'b1;
					end
					IC_STATUS: begin
						if (phase_q == PH_POLL) begin
							if (!head.busy) begin
								if (chip_q || next_blk >= {5'b0, end_q}) begin
									res_d   = mk_done(ST_OK, jlen_q);
									res_we  = 1'b1;
									phase_d = PH_IDLE;
								end else begin
									// Step to the next block
									res_d     = mk_cmd(OP_WREN, 27'd0, 3'd0, 1'b0, 1'b0);
									res_we    = 1'b1;
									seq_d     = SEQ_ERASE;
									plan_we   = 1'b1;
									op2_d     = cfg.erase_opcode;
									addr2_d   = eaddr;
									ab2_d     = eab;
									baddr_d   = next_blk[26:0];
									elapsed_d = 18'd0;
								end
							end else if (elapsed_q > limit) begin
								res_d   = mk_done(ST_TIMEOUT, 28'd0);
								res_we  = 1'b1;
								phase_d = PH_IDLE;
							end else begin
								res_d  = mk_cmd(OP_RDSR, 27'd0, 3'd0, 1'b1, 1'b1);
								res_we = 1'b1;
							end
						end
					end
					IC_TICK: begin
						if (phase_q == PH_POLL && elapsed_q != ELAPSED_MAX)
							elapsed_d = elapsed_q + 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// Hold job and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			baddr_q     <= '0;
			end_q       <= '0;
			elapsed_q   <= '0;
			chip_q      <= 1'b0;
			jlen_q      <= '0;
			seq_q       <= SEQ_NONE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			baddr_q   <= baddr_d;
			end_q     <= end_d;
			elapsed_q <= elapsed_d;
			chip_q    <= chip_d;
			jlen_q    <= jlen_d;
			seq_q     <= seq_d;
			if (out_load)
				out_valid_q <= res_we;
		end
	end

	// Load payload registers
	always_ff @(posedge clk) begin
		if (plan_we) begin
			op2_q   <= op2_d;
			addr2_q <= addr2_d;
			ab2_q   <= ab2_d;
		end
		if (res_we)
			out_q <= res_d;
	end

	assign res_ch.valid         = out_valid_q;
	assign res_ch.kind          = out_q.kind;
	assign res_ch.opcode        = out_q.opcode;
	assign res_ch.cmd_address   = out_q.cmd_address;
	assign res_ch.address_bytes = out_q.address_bytes;
	assign res_ch.wants_reply   = out_q.wants_reply;
	assign res_ch.done_status   = out_q.done_status;
	assign res_ch.done_length   = out_q.done_length;
	assign res_ch.last          = out_q.last;

	`SNE_ASSERT_IMP(a_burst_has_output, clk, arst_n, seq_q != SEQ_NONE, out_valid_q,
		"burst tail pending without a result in the output register")
	`SNE_ASSERT_IMP(a_burst_in_poll, clk, arst_n, seq_q != SEQ_NONE, phase_q == PH_POLL,
		"burst tail pending while no job runs")
	`SNE_ASSERT_NXT(a_done_goes_idle, clk, arst_n,
		res_we && res_d.kind && res_d.done_status != ST_BUSY, phase_q == PH_IDLE,
		"done report issued but job still running")

endmodule
`default_nettype wire

FILE: sv/spi_nor_erase_sequencer_core.sv
`default_nettype none
// SPI NOR erase sequencer. Items on req_ch are erase requests, status-byte
// replies and millisecond ticks; req_ch stays ready while the four-entry item
// queue has room, so items may arrive every cycle. A classifier checks ranges
// against the live configuration on entry, and the sequencer behind the queue
// turns each item into flash commands and done reports on res_ch through an
// output register. A request or status reply that starts an erase yields
// write-enable, erase and read-status commands in that order; every other
// item leaves the queue with at most one result. The queue is held while
// the output register is stalled or the single burst sequencer has a tail.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods. No clearing pass follows reset.
module spi_nor_erase_sequencer_core
	import sne_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	sne_req_if.sink                    req_ch,
	sne_res_if.source                  res_ch
);

	cfg_t    cfg;
	logic    q_full;
	logic    q_empty;
	logic    push;
	logic    pop;
	q_item_t push_item;
	q_item_t head;

	sne_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.req_ch    (req_ch),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	sne_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	sne_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.res_ch (res_ch)
	);

endmodule
`default_nettype wire
